>>> hdl/nlsu_pkg.sv
// Shared constants, types and codes of the natural log series unit.
`timescale 1ns / 1ps

package nlsu_pkg;

   // Default configuration of the datapath.
   localparam int WORK_FRAC_BITS_DEF = 62;
   localparam int SERIES_TERMS_DEF = 13;

   // Significand with hidden bit, unbiased exponent and divider remainder widths.
   localparam int SIG_BITS = 53;
   localparam int EXP_BITS = 12;
   localparam int REM_BITS = 55;

   // Decode stage, six normalize stages and the range reduction stage.
   localparam int FRONT_LAT = 8;

   // ln(2) in Q0.128, split in two 64-bit halves.
   localparam logic [63:0] LN2_HI = 64'hB17217F7D1CF79AB;
   localparam logic [63:0] LN2_LO = 64'hC9E3B39803F2F6AF;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NAN      = 2'd1,
      STATUS_NEG_INF  = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   // Control bundle that travels beside the data in every stage.
   typedef struct packed {
      logic                       valid;
      status_type                 status;
      logic signed [EXP_BITS-1:0] e;
      logic                       aneg;
   } side_type;

endpackage

>>> hdl/nlsu_front.sv
// Operand decode, subnormal normalization and range reduction.
`timescale 1ns / 1ps

module nlsu_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [63:0]                   x_bits,
   output logic [nlsu_pkg::REM_BITS-1:0] r_out,
   output logic [nlsu_pkg::REM_BITS-1:0] den_out,
   output nlsu_pkg::side_type            side_out
);
   import nlsu_pkg::*;

   logic [SIG_BITS-1:0]        sig_ff [0:6];
   logic signed [EXP_BITS-1:0] e_ff [0:6];
   side_type                   side_ff [0:6];

   logic [SIG_BITS-1:0]        sig_in;
   logic signed [EXP_BITS-1:0] e_in;
   side_type                   side_in;
   logic [10:0]                bexp;
   logic [51:0]                frac;

   // Decode the encoding and sort out the special operands.
   always_comb begin
      bexp = x_bits[62:52];
      frac = x_bits[51:0];
      side_in = '0;
      side_in.valid = start;
      if (bexp == 11'h7FF && frac != '0) begin
         side_in.status = STATUS_NAN;
      end else if (bexp == '0 && frac == '0) begin
         side_in.status = STATUS_NEG_INF;
      end else if (x_bits[63]) begin
         side_in.status = STATUS_NAN;
      end else if (bexp == 11'h7FF) begin
         side_in.status = STATUS_OVERFLOW;
      end else begin
         side_in.status = STATUS_OK;
      end
      if (bexp == '0) begin
         sig_in = {1'b0, frac};
         e_in = -12'sd1022;
      end else begin
         sig_in = {1'b1, frac};
         e_in = $signed({1'b0, bexp}) - 12'sd1023;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0] <= '0;
      end else begin
         side_ff[0] <= side_in;
      end
      sig_ff[0] <= sig_in;
      e_ff[0] <= e_in;
   end

   // Normalize by a binary search: each stage shifts by half the previous amount.
   for (genvar s = 0; s < 6; s++) begin : g_norm
      localparam int SH = 1 << (5 - s);
      logic [SIG_BITS-1:0]        nsig_in;
      logic signed [EXP_BITS-1:0] ne_in;

      always_comb begin
         if (sig_ff[s][SIG_BITS-1 -: SH] == '0) begin
            nsig_in = sig_ff[s] << SH;
            ne_in = e_ff[s] - EXP_BITS'(SH);
         end else begin
            nsig_in = sig_ff[s];
            ne_in = e_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[s+1] <= '0;
         end else begin
            side_ff[s+1] <= side_ff[s];
         end
         sig_ff[s+1] <= nsig_in;
         e_ff[s+1] <= ne_in;
      end
   end

   logic                 big;
   logic [REM_BITS-1:0]  one;
   logic [REM_BITS-1:0]  sig_w;
   logic [REM_BITS-1:0]  r_in;
   logic [REM_BITS-1:0]  den_in;
   side_type             rside_in;
   logic [REM_BITS-1:0]  r_ff;
   logic [REM_BITS-1:0]  den_ff;
   side_type             rside_ff;

   // Fold a significand above 1.5 down and form numerator and denominator of A.
   always_comb begin
      sig_w = REM_BITS'(sig_ff[6]);
      big = sig_ff[6] > (SIG_BITS'(3) << (SIG_BITS - 2));
      one = big ? (REM_BITS'(1) << SIG_BITS) : (REM_BITS'(1) << (SIG_BITS - 1));
      rside_in = side_ff[6];
      rside_in.e = e_ff[6] + EXP_BITS'(big);
      rside_in.aneg = sig_w < one;
      r_in = rside_in.aneg ? one - sig_w : sig_w - one;
      den_in = sig_w + one;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rside_ff <= '0;
      end else begin
         rside_ff <= rside_in;
      end
      r_ff <= r_in;
      den_ff <= den_in;
   end

   assign r_out = r_ff;
   assign den_out = den_ff;
   assign side_out = rside_ff;

endmodule

>>> hdl/nlsu_div_cell.sv
// One restoring division step: one quotient bit of |A| per cell.
`timescale 1ns / 1ps

module nlsu_div_cell #(
   parameter int FRAC_BITS = nlsu_pkg::WORK_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [nlsu_pkg::REM_BITS-1:0] r_in,
   input  logic [nlsu_pkg::REM_BITS-1:0] den_in,
   input  logic [FRAC_BITS-1:0]          q_in,
   input  nlsu_pkg::side_type            side_in,
   output logic [nlsu_pkg::REM_BITS-1:0] r_out,
   output logic [nlsu_pkg::REM_BITS-1:0] den_out,
   output logic [FRAC_BITS-1:0]          q_out,
   output nlsu_pkg::side_type            side_out
);
   import nlsu_pkg::*;

   logic [REM_BITS-1:0]  two_r;
   logic                 take;
   logic [REM_BITS-1:0]  r_ff;
   logic [REM_BITS-1:0]  den_ff;
   logic [FRAC_BITS-1:0] q_ff;
   side_type             side_ff;

   // Subtract the denominator when twice the remainder reaches it.
   always_comb begin
      two_r = {r_in[REM_BITS-2:0], 1'b0};
      take = two_r >= den_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else begin
         side_ff <= side_in;
      end
      r_ff <= take ? two_r - den_in : two_r;
      den_ff <= den_in;
      q_ff <= {q_in[FRAC_BITS-2:0], take};
   end

   assign r_out = r_ff;
   assign den_out = den_ff;
   assign q_out = q_ff;
   assign side_out = side_ff;

endmodule

>>> hdl/nlsu_mul_cell.sv
// Two-stage multiply, round to nearest and add cell of the series chain.
`timescale 1ns / 1ps

module nlsu_mul_cell #(
   parameter int FRAC_BITS = nlsu_pkg::WORK_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [FRAC_BITS+1:0]   a_in,
   input  logic [FRAC_BITS+1:0]   b_in,
   input  logic [FRAC_BITS+1:0]   add_in,
   input  logic [FRAC_BITS-1:0]   amag_in,
   input  logic [FRAC_BITS-1:0]   asq_in,
   input  nlsu_pkg::side_type     side_in,
   output logic [FRAC_BITS+1:0]   y_out,
   output logic [FRAC_BITS-1:0]   amag_out,
   output logic [FRAC_BITS-1:0]   asq_out,
   output nlsu_pkg::side_type     side_out
);
   import nlsu_pkg::*;

   localparam int PW = FRAC_BITS + 2;
   localparam int HW = PW - 32;
   localparam int PR = 2 * PW;

   logic [63:0]        p00_in, p00_ff;
   logic [31+HW:0]     p01_in, p01_ff;
   logic [31+HW:0]     p10_in, p10_ff;
   logic [2*HW-1:0]    p11_in, p11_ff;
   logic [PW-1:0]      add_ff;
   logic [FRAC_BITS-1:0] amag1_ff, asq1_ff, amag2_ff, asq2_ff;
   side_type           side1_ff, side2_ff;
   logic [PR-1:0]      full;
   logic [PW-1:0]      y_in, y_ff;

   // First stage: four partial products of at most 32 by 32 bits.
   always_comb begin
      p00_in = a_in[31:0] * b_in[31:0];
      p01_in = a_in[31:0] * b_in[PW-1:32];
      p10_in = a_in[PW-1:32] * b_in[31:0];
      p11_in = a_in[PW-1:32] * b_in[PW-1:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff <= '0;
         side2_ff <= '0;
      end else begin
         side1_ff <= side_in;
         side2_ff <= side1_ff;
      end
      p00_ff <= p00_in;
      p01_ff <= p01_in;
      p10_ff <= p10_in;
      p11_ff <= p11_in;
      add_ff <= add_in;
      amag1_ff <= amag_in;
      asq1_ff <= asq_in;
      amag2_ff <= amag1_ff;
      asq2_ff <= asq1_ff;
      y_ff <= y_in;
   end

   // Second stage: sum the partials, round half up to the working scale, add.
   always_comb begin
      full = PR'(p00_ff) + (PR'(p01_ff) << 32) + (PR'(p10_ff) << 32)
             + (PR'(p11_ff) << 64) + (PR'(1) << (FRAC_BITS - 1));
      y_in = PW'(full >> FRAC_BITS) + add_ff;
   end

   assign y_out = y_ff;
   assign amag_out = amag2_ff;
   assign asq_out = asq2_ff;
   assign side_out = side2_ff;

endmodule

>>> hdl/nlsu_final.sv
// Adds the exponent term e*ln2 to A*P and rounds the sum to Q11.52.
`timescale 1ns / 1ps

module nlsu_final #(
   parameter int FRAC_BITS = nlsu_pkg::WORK_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [FRAC_BITS+1:0] prod_in,
   input  nlsu_pkg::side_type   side_in,
   output logic                 valid_out,
   output logic [63:0]          log_out,
   output logic [1:0]           status_out
);
   import nlsu_pkg::*;

   logic [10:0]  eabs;
   logic [74:0]  hi_prod;
   logic [74:0]  lo_prod;
   logic [127:0] t_pos, u_pos, t_in, u_in, t_ff, u_ff;
   logic [127:0] sum;
   side_type     side_ff;
   logic         valid_ff;
   logic [63:0]  log_ff, log_in;
   status_type   status_ff;

   // Exponent term at Q64 and the series term moved to Q64, both signed.
   always_comb begin
      eabs = 11'(side_in.e < 0 ? -side_in.e : side_in.e);
      hi_prod = 75'(eabs) * 75'(LN2_HI);
      lo_prod = 75'(eabs) * 75'(LN2_LO);
      t_pos = 128'(hi_prod) + 128'(lo_prod >> 64);
      t_in = side_in.e < 0 ? -t_pos : t_pos;
      u_pos = 128'(prod_in) << (64 - FRAC_BITS);
      u_in = side_in.aneg ? -u_pos : u_pos;
   end

   // Round halves upward and keep Q11.52; special cases read zero.
   always_comb begin
      sum = t_ff + u_ff + (128'd1 << 11);
      log_in = (side_ff.status == STATUS_OK) ? sum[75:12] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         side_ff <= side_in;
         valid_ff <= side_ff.valid;
      end
      t_ff <= t_in;
      u_ff <= u_in;
      log_ff <= log_in;
      status_ff <= side_ff.status;
   end

   assign valid_out = valid_ff;
   assign log_out = log_ff;
   assign status_out = status_ff;

endmodule

>>> hdl/natural_log_series_unit.sv
// Top level of the natural log series unit: a pipelined chain of cells.
//
// Use: drive req_x_bits with a binary64 bit pattern and raise start. Since
// busy is always low, one operand is taken at every clock edge that sees
// start high, so a new beat may follow in every cycle.
// Each operand yields exactly one result beat: rsp_valid is high for one
// cycle with rsp_log_value (ln x, two's complement Q11.52, rounded) and
// rsp_status (ok, nan, minus infinity, overflow). rsp_log_value is zero
// unless the status is ok.
// The chain is made of 8 front stages, one divider cell per quotient bit,
// one rounding stage, the SERIES_TERMS + 1 multiply cells and two output
// stages. Throughput is one beat per cycle.
// Results come out in the order of the operands.
// Reset (synchronous, active high) clears every valid bit in the chain, so
// beats in flight are dropped; there is no clearing pass.
// The receiver cannot stall; results are presented once and not held.
`timescale 1ns / 1ps

module natural_log_series_unit #(
   parameter int WORK_FRAC_BITS = nlsu_pkg::WORK_FRAC_BITS_DEF,
   parameter int SERIES_TERMS = nlsu_pkg::SERIES_TERMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_x_bits,
   output logic        rsp_valid,
   output logic signed [63:0] rsp_log_value,
   output logic [1:0]  rsp_status
);
   import nlsu_pkg::*;

   localparam int F = WORK_FRAC_BITS;
   localparam int T = SERIES_TERMS;
   localparam int PW = F + 2;
   localparam int LAT = FRONT_LAT + F + 1 + 2 * (T + 1) + 2;

   // The pipeline takes a beat in every cycle.
   assign busy = 1'b0;

   logic [REM_BITS-1:0] dr [0:F];
   logic [REM_BITS-1:0] dden [0:F];
   logic [F-1:0]        dq [0:F];
   side_type            dside [0:F];

   // Front end: decode, normalize and reduce the operand.
   nlsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .x_bits   (req_x_bits),
      .r_out    (dr[0]),
      .den_out  (dden[0]),
      .side_out (dside[0])
   );
   assign dq[0] = '0;

   // Divider chain producing |A| one bit per cell.
   for (genvar i = 0; i < F; i++) begin : g_div
      nlsu_div_cell #(.FRAC_BITS(F)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .r_in     (dr[i]),
         .den_in   (dden[i]),
         .q_in     (dq[i]),
         .side_in  (dside[i]),
         .r_out    (dr[i+1]),
         .den_out  (dden[i+1]),
         .q_out    (dq[i+1]),
         .side_out (dside[i+1])
      );
   end

   // Round the quotient to nearest, ties up.
   logic [F-1:0] amag_ff;
   side_type     aside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         aside_ff <= '0;
      end else begin
         aside_ff <= dside[F];
      end
      amag_ff <= dq[F] + F'({dr[F][REM_BITS-2:0], 1'b0} >= dden[F]);
   end

   logic [PW-1:0] cy [0:T];
   logic [F-1:0]  camag [0:T];
   logic [F-1:0]  casq [0:T];
   side_type      cside [0:T];

   // Multiply chain: square of A, Horner steps, then the product A*P.
   for (genvar j = 0; j <= T; j++) begin : g_mul
      logic [PW-1:0] a_sel, b_sel, add_sel;
      logic [F-1:0]  amag_sel, asq_sel;
      side_type      side_sel;

      if (j == 0) begin : g_sq
         assign a_sel = PW'(amag_ff);
         assign b_sel = PW'(amag_ff);
         assign add_sel = '0;
         assign amag_sel = amag_ff;
         assign asq_sel = amag_ff;
         assign side_sel = aside_ff;
      end else if (j < T) begin : g_horner
         localparam int KA = T - 1 - j;
         localparam logic [PW-1:0] COEF_ADD = PW'(((128'd1 << (F + 1)) + 128'(KA))
                                                  / 128'(2 * KA + 1));
         localparam logic [PW-1:0] COEF_LEAD = PW'(((128'd1 << (F + 1)) + 128'(T - 1))
                                                   / 128'(2 * T - 1));
         assign a_sel = (j == 1) ? COEF_LEAD : cy[j-1];
         assign b_sel = (j == 1) ? PW'(cy[0][F-1:0]) : PW'(casq[j-1]);
         assign add_sel = COEF_ADD;
         assign amag_sel = camag[j-1];
         assign asq_sel = (j == 1) ? cy[0][F-1:0] : casq[j-1];
         assign side_sel = cside[j-1];
      end else begin : g_prod
         assign a_sel = PW'(camag[j-1]);
         assign b_sel = cy[j-1];
         assign add_sel = '0;
         assign amag_sel = camag[j-1];
         assign asq_sel = casq[j-1];
         assign side_sel = cside[j-1];
      end

      nlsu_mul_cell #(.FRAC_BITS(F)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .a_in     (a_sel),
         .b_in     (b_sel),
         .add_in   (add_sel),
         .amag_in  (amag_sel),
         .asq_in   (asq_sel),
         .side_in  (side_sel),
         .y_out    (cy[j]),
         .amag_out (camag[j]),
         .asq_out  (casq[j]),
         .side_out (cside[j])
      );
   end

   logic [63:0] log_out;

   // Exponent term, final sum and output register.
   nlsu_final #(.FRAC_BITS(F)) u_final (
      .clock      (clock),
      .reset      (reset),
      .prod_in    (cy[T]),
      .side_in    (cside[T]),
      .valid_out  (rsp_valid),
      .log_out    (log_out),
      .status_out (rsp_status)
   );
   assign rsp_log_value = $signed(log_out);

   // A result beat only ever follows an operand by the fixed latency.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result beat without an operand at the pipeline latency");

   // Special cases always carry a zero value.
   a_special_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_log_value == '0))
      else $error("nonzero value with a special status");

   // |A| never exceeds one third, so the rounded quotient keeps its top bit clear.
   a_amag_range: assert property (@(posedge clock) disable iff (reset)
      (aside_ff.valid && aside_ff.status == STATUS_OK) |-> (amag_ff[F-1] == 1'b0))
      else $error("quotient out of range after rounding");

endmodule
